### rtl/core/parp_pkg.sv
package parp_pkg;

   localparam int RING_DEPTH_DEFAULT = 1024;
   localparam int PHASE_WRAP = 6250;
   localparam logic [7:0] SILENCE_FLIP = 8'h80;

   localparam int OP_W = 3;
   localparam int ADDR_W = 10;
   localparam int BYTE_W = 8;
   localparam int POS_W = 10;
   localparam int RATE_W = 13;
   localparam int STEP_W = 3;
   localparam int OFFS_W = 2;
   localparam int ACC_W = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [RATE_W-1:0] RATE_STEP_RESET = 13'd4410;
   localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 3'd0;
   localparam logic [OFFS_W-1:0] LEFT_OFFSET_RESET = 2'd0;
   localparam logic [OFFS_W-1:0] RIGHT_OFFSET_RESET = 2'd2;
   localparam logic [BYTE_W-1:0] SAMPLE_BIAS_RESET = 8'd128;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_LEVEL   = 3'd2,
      OP_MUTE    = 3'd3,
      OP_RESUME  = 3'd4,
      OP_RESTART = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_STEP    = 3'd0,
      CSR_STEP_SIZE    = 3'd1,
      CSR_LEFT_OFFSET  = 3'd2,
      CSR_RIGHT_OFFSET = 3'd3,
      CSR_SAMPLE_BIAS  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      WT_ADDR,
      WT_LEFT,
      WT_RIGHT,
      WT_FILL
   } wr_target_type;

   typedef struct packed {
      logic          load_item;
      logic          rd_en;
      logic          rd_right;
      logic          cap_left;
      logic          wr_en;
      wr_target_type wr_target;
      logic          fill_begin;
      logic          finish;
   } parp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic out_free;
   } parp_stat_type;

endpackage

### rtl/core/parp_ctrl.sv
module parp_ctrl
   import parp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [OP_W-1:0]  req_op,
   output logic             req_ready,
   output parp_cmd_type     cmd,
   input  parp_stat_type    stat
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_L,
      S_RD_R,
      S_WR_A,
      S_WR_L,
      S_WR_R,
      S_FILL,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_target = WT_FILL;
            if (stat.fill_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (op_type'(req_op))
                  OP_TICK:         state_in = S_RD_L;
                  OP_WRITE:        state_in = S_WR_A;
                  OP_LEVEL,
                  OP_MUTE:         state_in = S_WR_L;
                  OP_RESTART: begin
                     cmd.fill_begin = 1'b1;
                     state_in = S_FILL;
                  end
                  default:         state_in = S_DONE;
               endcase
            end
         end
         S_RD_L: begin
            cmd.rd_en = 1'b1;
            state_in = S_RD_R;
         end
         S_RD_R: begin
            cmd.rd_en = 1'b1;
            cmd.rd_right = 1'b1;
            cmd.cap_left = 1'b1;
            state_in = S_DONE;
         end
         S_WR_A: begin
            cmd.wr_en = 1'b1;
            cmd.wr_target = WT_ADDR;
            state_in = S_DONE;
         end
         S_WR_L: begin
            cmd.wr_en = 1'b1;
            cmd.wr_target = WT_LEFT;
            state_in = S_WR_R;
         end
         S_WR_R: begin
            cmd.wr_en = 1'b1;
            cmd.wr_target = WT_RIGHT;
            state_in = S_DONE;
         end
         S_FILL: begin
            cmd.wr_en = 1'b1;
            cmd.wr_target = WT_FILL;
            if (stat.fill_last) state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register can take the transfer
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/parp_dpath.sv
module parp_dpath
   import parp_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [BYTE_W-1:0]     req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  parp_cmd_type          cmd,
   output parp_stat_type         stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_left_level,
   output logic [BYTE_W-1:0]     rsp_right_level,
   output logic                  rsp_level_valid,
   output logic [POS_W-1:0]      rsp_position
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int WORK_W = IDX_W + 4;

   // configuration
   logic [RATE_W-1:0] rate_step_ff;
   logic [STEP_W-1:0] step_size_ff;
   logic [OFFS_W-1:0] left_offset_ff;
   logic [OFFS_W-1:0] right_offset_ff;
   logic [BYTE_W-1:0] sample_bias_ff;

   // latched item
   op_type            op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [BYTE_W-1:0] data_ff;

   // player state
   logic [ACC_W-1:0] acc_ff;
   logic [IDX_W-1:0] pos_ff;
   logic             muted_ff;

   logic [IDX_W-1:0]  fill_cnt_ff;
   logic [BYTE_W-1:0] fill_val_ff;

   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic [BYTE_W-1:0] left_ff;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_left_ff;
   logic [BYTE_W-1:0] rsp_right_ff;
   logic              rsp_level_valid_ff;
   logic [POS_W-1:0]  rsp_position_ff;

   logic [IDX_W:0]    left_sum;
   logic [IDX_W:0]    right_sum;
   logic [IDX_W:0]    step_sum;
   logic [IDX_W-1:0]  left_idx;
   logic [IDX_W-1:0]  right_idx;
   logic [IDX_W-1:0]  step_idx;
   logic [WORK_W-1:0] addr_w;
   logic [IDX_W-1:0]  addr_idx;
   logic [BYTE_W-1:0] silence;
   logic [IDX_W-1:0]  waddr;
   logic [BYTE_W-1:0] wdata;
   logic [IDX_W-1:0]  raddr;
   logic [RATE_W-1:0] rate_eff;
   logic [ACC_W:0]    acc_sum;
   logic              acc_wrap;
   logic [ACC_W-1:0]  acc_in;
   logic [IDX_W-1:0]  pos_in;
   logic [IDX_W-1:0]  pos_sel;
   logic [WORK_W-1:0] pos_w;

   // ring index arithmetic: one compare and subtract wraps each sum
   always_comb begin
      left_sum = {1'b0, pos_ff} + (IDX_W+1)'(left_offset_ff);
      right_sum = {1'b0, pos_ff} + (IDX_W+1)'(right_offset_ff);
      step_sum = {1'b0, pos_ff} + (IDX_W+1)'(step_size_ff);
      if (left_sum >= (IDX_W+1)'(RING_DEPTH)) left_sum = left_sum - (IDX_W+1)'(RING_DEPTH);
      if (right_sum >= (IDX_W+1)'(RING_DEPTH)) right_sum = right_sum - (IDX_W+1)'(RING_DEPTH);
      if (step_sum >= (IDX_W+1)'(RING_DEPTH)) step_sum = step_sum - (IDX_W+1)'(RING_DEPTH);
      left_idx = left_sum[IDX_W-1:0];
      right_idx = right_sum[IDX_W-1:0];
      step_idx = step_sum[IDX_W-1:0];
   end

   // reduce the byte address modulo the ring depth by restoring steps
   always_comb begin
      addr_w = WORK_W'(addr_ff);
      for (int k = 3; k >= 0; k--) begin
         if (addr_w >= WORK_W'(RING_DEPTH << k)) addr_w = addr_w - WORK_W'(RING_DEPTH << k);
      end
      addr_idx = addr_w[IDX_W-1:0];
   end

   assign silence = sample_bias_ff ^ SILENCE_FLIP;

   always_comb begin
      case (cmd.wr_target)
         WT_ADDR:  waddr = addr_idx;
         WT_LEFT:  waddr = left_idx;
         WT_RIGHT: waddr = right_idx;
         WT_FILL:  waddr = fill_cnt_ff;
         default:  waddr = fill_cnt_ff;
      endcase
      if (cmd.wr_target == WT_FILL) begin
         wdata = fill_val_ff;
      end else if (op_ff == OP_MUTE) begin
         wdata = silence;
      end else begin
         wdata = data_ff;
      end
   end

   assign raddr = cmd.rd_right ? right_idx : left_idx;

   // phase accumulator and position advance for a tick
   always_comb begin
      rate_eff = (rate_step_ff > RATE_W'(PHASE_WRAP)) ? RATE_W'(PHASE_WRAP) : rate_step_ff;
      acc_sum = {1'b0, acc_ff} + (ACC_W+1)'(rate_eff);
      acc_wrap = acc_sum >= (ACC_W+1)'(PHASE_WRAP);
      if (acc_wrap) begin
         acc_sum = acc_sum - (ACC_W+1)'(PHASE_WRAP);
      end
      acc_in = acc_sum[ACC_W-1:0];
      pos_in = (acc_wrap && !muted_ff) ? step_idx : pos_ff;
      case (op_ff)
         OP_TICK:    pos_sel = pos_in;
         OP_RESTART: pos_sel = '0;
         default:    pos_sel = pos_ff;
      endcase
      pos_w = WORK_W'(pos_sel);
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) ring_mem[waddr] <= wdata;
      if (cmd.rd_en) rdata_ff <= ring_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff <= op_type'(req_op);
         addr_ff <= req_address;
         data_ff <= req_data;
      end
      if (cmd.cap_left) left_ff <= rdata_ff + sample_bias_ff;
      if (cmd.finish) begin
         if (op_ff == OP_TICK) begin
            rsp_left_ff <= left_ff;
            rsp_right_ff <= rdata_ff + sample_bias_ff;
            rsp_level_valid_ff <= 1'b1;
         end else begin
            rsp_left_ff <= '0;
            rsp_right_ff <= '0;
            rsp_level_valid_ff <= 1'b0;
         end
         rsp_position_ff <= pos_w[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_step_ff <= RATE_STEP_RESET;
         step_size_ff <= STEP_SIZE_RESET;
         left_offset_ff <= LEFT_OFFSET_RESET;
         right_offset_ff <= RIGHT_OFFSET_RESET;
         sample_bias_ff <= SAMPLE_BIAS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_RATE_STEP:    rate_step_ff <= csr_wdata[RATE_W-1:0];
            CSR_STEP_SIZE:    step_size_ff <= csr_wdata[STEP_W-1:0];
            CSR_LEFT_OFFSET:  left_offset_ff <= csr_wdata[OFFS_W-1:0];
            CSR_RIGHT_OFFSET: right_offset_ff <= csr_wdata[OFFS_W-1:0];
            CSR_SAMPLE_BIAS:  sample_bias_ff <= csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pos_ff <= '0;
         muted_ff <= 1'b0;
         fill_cnt_ff <= '0;
         fill_val_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fill_begin) begin
            fill_cnt_ff <= '0;
            fill_val_ff <= silence;
         end else if (cmd.wr_en && cmd.wr_target == WT_FILL) begin
            fill_cnt_ff <= fill_cnt_ff + 1'b1;
         end
         if (cmd.finish) begin
            case (op_ff)
               OP_TICK: begin
                  acc_ff <= acc_in;
                  pos_ff <= pos_in;
               end
               OP_MUTE:   muted_ff <= 1'b1;
               OP_RESUME: muted_ff <= 1'b0;
               OP_RESTART: begin
                  acc_ff <= '0;
                  pos_ff <= '0;
                  muted_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.fill_last = fill_cnt_ff == IDX_W'(RING_DEPTH - 1);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_level = rsp_left_ff;
   assign rsp_right_level = rsp_right_ff;
   assign rsp_level_valid = rsp_level_valid_ff;
   assign rsp_position = rsp_position_ff;

endmodule

### rtl/core/pwm_audio_ring_player.sv
// PWM audio ring player. Software loads sample bytes into a ring of RING_DEPTH bytes
// (write byte); each tick reads the left and right bytes at the play position plus
// their offsets and returns them plus the bias as PWM compare values, while a phase
// accumulator steps the position. Items are handled one at a time through a single
// ported ring memory: a tick does two reads, a byte write one write, set level and
// mute two writes each, resume and undefined ops none, and restart refills the ring
// with silence. After reset the block clears the ring before it takes its first
// item; configuration writes are taken at any time and apply at once.
module pwm_audio_ring_player
   import parp_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [BYTE_W-1:0]     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_left_level,
   output logic [BYTE_W-1:0]     rsp_right_level,
   output logic                  rsp_level_valid,
   output logic [POS_W-1:0]      rsp_position,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   parp_cmd_type  cmd;
   parp_stat_type stat;

   parp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   parp_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_address     (req_address),
      .req_data        (req_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_level  (rsp_left_level),
      .rsp_right_level (rsp_right_level),
      .rsp_level_valid (rsp_level_valid),
      .rsp_position    (rsp_position)
   );

`ifndef ASSERT_OFF
   // the ring has a single port: never read and write in one cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("ring read and write in the same cycle");

   // every item takes the block out of idle after its transfer, so ready drops
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // non-tick results carry zero levels
   a_zero_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_level_valid |-> rsp_left_level == '0 && rsp_right_level == '0)
      else $error("levels set on a non-tick result");

   // a result is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid || rsp_ready)
      else $error("result register overwritten");
`endif

endmodule

### tb/tb.sv
module tb;
   import parp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEMS_PER_PHASE = 250;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] data;
   } ring_cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] left_lvl;
      logic [BYTE_W-1:0] right_lvl;
      logic              lvl_valid;
      logic [POS_W-1:0]  pos;
   } level_frame_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic [BYTE_W-1:0] req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_left_level;
   logic [BYTE_W-1:0] rsp_right_level;
   logic rsp_level_valid;
   logic [POS_W-1:0] rsp_position;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // player shadow: ring image, phase, position, mute and registers
   logic [BYTE_W-1:0] ring_img [0:RING_DEPTH_DEFAULT-1];
   int unsigned phase_acc;
   logic [POS_W-1:0] play_pos;
   bit is_muted;
   logic [RATE_W-1:0] cfg_rate;
   logic [STEP_W-1:0] cfg_step;
   logic [OFFS_W-1:0] cfg_loff;
   logic [OFFS_W-1:0] cfg_roff;
   logic [BYTE_W-1:0] cfg_bias;

   ring_cmd_type cmds_waiting[$];
   level_frame_type frames_due[$];

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   logic req_fired = 1'b0;
   int unsigned sent_count = 0;
   int unsigned checked_count = 0;
   int unsigned tick_count = 0;
   int unsigned restart_count = 0;
   int unsigned fail_count = 0;
   int unsigned hold_from = '1;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   int unsigned cycle_count = 0;

   pwm_audio_ring_player DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_address     (req_address),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_level  (rsp_left_level),
      .rsp_right_level (rsp_right_level),
      .rsp_level_valid (rsp_level_valid),
      .rsp_position    (rsp_position),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic level_frame_type player_step(input ring_cmd_type c);
      level_frame_type r;
      logic [POS_W-1:0] li;
      logic [POS_W-1:0] ri;
      logic [BYTE_W-1:0] silence;
      int unsigned rate;
      r = '0;
      li = play_pos + POS_W'(cfg_loff);
      ri = play_pos + POS_W'(cfg_roff);
      silence = cfg_bias ^ SILENCE_FLIP;
      case (c.op)
         OP_TICK: begin
            rate = (cfg_rate > PHASE_WRAP) ? PHASE_WRAP : cfg_rate;
            r.left_lvl = ring_img[li] + cfg_bias;
            r.right_lvl = ring_img[ri] + cfg_bias;
            r.lvl_valid = 1'b1;
            phase_acc += rate;
            if (phase_acc >= PHASE_WRAP) begin
               phase_acc -= PHASE_WRAP;
               if (!is_muted) play_pos = play_pos + POS_W'(cfg_step);
            end
         end
         OP_WRITE: ring_img[c.address] = c.data;
         OP_LEVEL: begin
            ring_img[li] = c.data;
            ring_img[ri] = c.data;
         end
         OP_MUTE: begin
            is_muted = 1'b1;
            ring_img[li] = silence;
            ring_img[ri] = silence;
         end
         OP_RESUME: is_muted = 1'b0;
         OP_RESTART: begin
            phase_acc = 0;
            play_pos = '0;
            is_muted = 1'b0;
            for (int i = 0; i < RING_DEPTH_DEFAULT; i++) ring_img[i] = silence;
         end
         default: ;
      endcase
      r.pos = play_pos;
      return r;
   endfunction

   // mostly ticks and writes close to the play position so reads hit fresh bytes
   function automatic ring_cmd_type random_cmd();
      ring_cmd_type c;
      int unsigned pick;
      pick = $urandom_range(999);
      c.address = ADDR_W'($urandom);
      c.data = BYTE_W'($urandom);
      if (pick < 440 || pick >= 930) begin
         c.op = OP_TICK;
      end else if (pick < 740) begin
         c.op = OP_WRITE;
         if ($urandom_range(1)) c.address = play_pos + ADDR_W'($urandom_range(12));
      end else if (pick < 800) begin
         c.op = OP_LEVEL;
      end else if (pick < 830) begin
         c.op = OP_MUTE;
      end else if (pick < 900) begin
         c.op = OP_RESUME;
      end else if (pick < 910) begin
         c.op = OP_RESTART;
      end else begin
         c.op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      end
      return c;
   endfunction

   task automatic flag(input string text);
      fail_count++;
      if (fail_count <= 10) $display("%s", text);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_RATE_STEP:    cfg_rate = value[RATE_W-1:0];
         CSR_STEP_SIZE:    cfg_step = value[STEP_W-1:0];
         CSR_LEFT_OFFSET:  cfg_loff = value[OFFS_W-1:0];
         CSR_RIGHT_OFFSET: cfg_roff = value[OFFS_W-1:0];
         CSR_SAMPLE_BIAS:  cfg_bias = value[BYTE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic apply_setting(input logic [RATE_W-1:0] rate, input logic [STEP_W-1:0] step,
                                input logic [OFFS_W-1:0] loff, input logic [OFFS_W-1:0] roff,
                                input logic [BYTE_W-1:0] bias);
      write_reg(CSR_RATE_STEP, CSR_DATA_W'(rate));
      write_reg(CSR_STEP_SIZE, CSR_DATA_W'(step));
      write_reg(CSR_LEFT_OFFSET, CSR_DATA_W'(loff));
      write_reg(CSR_RIGHT_OFFSET, CSR_DATA_W'(roff));
      write_reg(CSR_SAMPLE_BIAS, CSR_DATA_W'(bias));
   endtask

   task automatic put(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address,
                      input logic [BYTE_W-1:0] data);
      ring_cmd_type c;
      c.op = op;
      c.address = address;
      c.data = data;
      cmds_waiting.push_back(c);
   endtask

   // keep the queue short so write addresses follow the live play position
   task automatic feed_random(input int unsigned count);
      ring_cmd_type c;
      int unsigned made;
      made = 0;
      while (made < count) begin
         @(posedge clock);
         if (cmds_waiting.size() < 2) begin
            c = random_cmd();
            cmds_waiting.push_back(c);
            if (c.op <= OP_RESTART) made++;
         end
      end
   endtask

   // check at the rising edge, where a popped item already shows as valid
   task automatic drain();
      @(posedge clock);
      while (cmds_waiting.size() != 0 || req_valid || frames_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // driver: hold the payload until the transfer, then offer the next item
   always @(negedge clock) begin
      ring_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (cmds_waiting.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            c = cmds_waiting.pop_front();
            req_valid <= 1'b1;
            req_op <= c.op;
            req_address <= c.address;
            req_data <= c.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
   end

   // long receiver stall once the pressure phase has moved 40 items
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && sent_count >= hold_from) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: check result transfers, predict on request transfers
   always @(posedge clock) begin
      level_frame_type want;
      level_frame_type got;
      ring_cmd_type c;
      if (reset) begin
         req_fired <= 1'b0;
         for (int i = 0; i < RING_DEPTH_DEFAULT; i++) ring_img[i] = '0;
         phase_acc = 0;
         play_pos = '0;
         is_muted = 1'b0;
         cfg_rate = RATE_STEP_RESET;
         cfg_step = STEP_SIZE_RESET;
         cfg_loff = LEFT_OFFSET_RESET;
         cfg_roff = RIGHT_OFFSET_RESET;
         cfg_bias = SAMPLE_BIAS_RESET;
      end else begin
         req_fired <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            got.left_lvl = rsp_left_level;
            got.right_lvl = rsp_right_level;
            got.lvl_valid = rsp_level_valid;
            got.pos = rsp_position;
            if (frames_due.size() == 0) begin
               flag($sformatf("unexpected result: left %02h right %02h valid %0b pos %0d",
                              got.left_lvl, got.right_lvl, got.lvl_valid, got.pos));
            end else begin
               want = frames_due.pop_front();
               if (got.left_lvl !== want.left_lvl || got.right_lvl !== want.right_lvl ||
                   got.lvl_valid !== want.lvl_valid || got.pos !== want.pos)
                  flag($sformatf({"result %0d mismatch: expected left %02h right %02h ",
                                  "valid %0b pos %0d, got left %02h right %02h valid %0b pos %0d"},
                                 checked_count, want.left_lvl, want.right_lvl, want.lvl_valid,
                                 want.pos, got.left_lvl, got.right_lvl, got.lvl_valid, got.pos));
            end
            checked_count++;
         end
         if (req_valid && req_ready) begin
            c.op = req_op;
            c.address = req_address;
            c.data = req_data;
            if (c.op == OP_TICK) tick_count++;
            if (c.op == OP_RESTART) restart_count++;
            frames_due.push_back(player_step(c));
            sent_count <= sent_count + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, frames_due.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: rate above range acts as full rate, step 7, bias 255
      tx_idle_pct = 20;
      rx_idle_pct = 84;
      apply_setting(13'd8191, 3'd7, 2'd3, 2'd1, 8'd255);
      @(posedge clock);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_WRITE, 10'd0, 8'd0);
      put(OP_WRITE, 10'd1023, 8'hFF);
      put(OP_WRITE, 10'd17, 8'h01);
      put(OP_WRITE, 10'd15, 8'h80);
      put(OP_TICK, 10'd1023, 8'hFF);
      put(OP_UNDEF_LO, 10'd1023, 8'hFF);
      put(OP_UNDEF_HI, 10'd0, 8'h00);
      put(OP_LEVEL, 10'd0, 8'hAA);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_MUTE, 10'd0, 8'd0);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_RESUME, 10'd0, 8'd0);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_RESTART, 10'd0, 8'd0);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_WRITE, 10'd1023, 8'h55);
      put(OP_WRITE, 10'd8, 8'hFF);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_MUTE, 10'd0, 8'd0);
      put(OP_RESTART, 10'd0, 8'd0);
      put(OP_TICK, 10'd0, 8'd0);
      put(OP_TICK, 10'd0, 8'd0);
      drain();

      apply_setting(13'd6250, 3'd5, 2'd2, 2'd3, 8'd0);
      feed_random(ITEMS_PER_PHASE);
      drain();

      tx_idle_pct = 84;
      rx_idle_pct = 20;
      apply_setting(13'd0, 3'd0, 2'd0, 2'd0, 8'd128);
      feed_random(ITEMS_PER_PHASE);
      drain();

      apply_setting(RATE_W'($urandom_range(1, 6249)), STEP_W'($urandom_range(1, 4)),
                    OFFS_W'($urandom_range(3)), OFFS_W'($urandom_range(3)),
                    BYTE_W'($urandom_range(1, 254)));
      feed_random(ITEMS_PER_PHASE);
      drain();

      // no idling; receiver stalls once so the block backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_from = sent_count + 40;
      apply_setting(13'd3125, 3'd2, 2'd1, 2'd3, 8'h80);
      feed_random(ITEMS_PER_PHASE);
      drain();

      if (frames_due.size() != 0)
         flag($sformatf("%0d expected results never arrived", frames_due.size()));
      $display("covered %0d transfers (%0d ticks, %0d restarts) over five register settings,",
               sent_count, tick_count, restart_count);
      $display("%0d results checked, %0d failures", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
